// File: sv/trsmc_pkg.sv
`timescale 1ns / 1ps
package trsmc_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_ENT   = 9;
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned DIV_STG   = DIV_STEPS + 1;
  localparam int unsigned Q_W       = DIV_STEPS + 1;
  localparam int unsigned ENT_W     = DIV_STEPS + 1;
  localparam int unsigned PROD_W    = ENT_W + WORD_W;

  localparam logic signed [ENT_W-1:0] FRAC_ONE = ENT_W'(65536);
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [63:0] wide_t;
  typedef logic signed [65:0] numer_t;
  typedef logic [Q_W-1:0] quot_t;
  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // most negative code is folded onto its neighbor so that the sum of squares stays in range
  function automatic word_t clamp_q(input word_t v);
    return (v == WORD_MIN) ? (WORD_MIN + 32'sd1) : v;
  endfunction

endpackage

// File: sv/trs_matrix_compose.sv
`timescale 1ns / 1ps
// Composes a 3x4 affine transform (rotation from an unnormalized quaternion,
// per-column scale, translation in the last column) from one item per clock.
// Throughput is one item every cycle while the result side does not stall. The
// pipe runs through the nine restoring dividers (one per rotation entry) that
// take one quotient bit per stage over 18 stages, plus products, sums, norm,
// magnitude, rounding, scale multiply and saturation stages.
// A stall at the result side freezes the whole pipe; item_ready follows it.
module trs_matrix_compose
  import trsmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] quat_w,
  input  logic [31:0] quat_x,
  input  logic [31:0] quat_y,
  input  logic [31:0] quat_z,
  input  logic [31:0] scale_x,
  input  logic [31:0] scale_y,
  input  logic [31:0] scale_z,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] m00,
  output logic [31:0] m01,
  output logic [31:0] m02,
  output logic [31:0] m03,
  output logic [31:0] m10,
  output logic [31:0] m11,
  output logic [31:0] m12,
  output logic [31:0] m13,
  output logic [31:0] m20,
  output logic [31:0] m21,
  output logic [31:0] m22,
  output logic [31:0] m23
);

  logic adv;

  // stage 1: products
  logic  v1;
  wide_t p_ww, p_xx, p_yy, p_zz;
  logic signed [63:0] p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  word_t s1_scl [3];
  word_t s1_pos [3];

  // stage 2: pair sums and cross terms
  logic  v2;
  wide_t a_wx, a_yz, a_wy, a_xz, a_wz, a_xy;
  logic signed [64:0] h01, h02, h10, h12, h20, h21;
  word_t s2_scl [3];
  word_t s2_pos [3];

  // stage 3: norm and signed numerators
  logic   v3;
  wide_t  s3_n;
  numer_t s3_d [NUM_ENT];
  word_t  s3_scl [3];
  word_t  s3_pos [3];

  // stage 4: magnitudes
  logic  v4;
  wide_t s4_n;
  logic  s4_zero;
  wide_t s4_mag [NUM_ENT];
  logic  [NUM_ENT-1:0] s4_neg;
  word_t s4_scl [3];
  word_t s4_pos [3];

  // divider stages
  logic  [DIV_STG-1:0] dv_vld;
  wide_t dv_rem [DIV_STG][NUM_ENT];
  quot_t dv_q   [DIV_STG][NUM_ENT];
  logic  [NUM_ENT-1:0] dv_neg [DIV_STG];
  wide_t dv_n   [DIV_STG];
  logic  [DIV_STG-1:0] dv_zero;
  word_t dv_scl [DIV_STG][3];
  word_t dv_pos [DIV_STG][3];

  // rounded entries
  logic  vr;
  ent_t  r_ent [NUM_ENT];
  word_t r_scl [3];
  word_t r_pos [3];

  // scaled products
  logic  vm;
  prod_t m_prod [NUM_ENT];
  word_t m_pos [3];

  // output register
  logic  vo;
  word_t o_ent [NUM_ENT];
  word_t o_pos [3];

  assign adv        = !vo || result_ready;
  assign item_ready = adv;

  word_t cw, cx, cy, cz;
  assign cw = clamp_q(word_t'(quat_w));
  assign cx = clamp_q(word_t'(quat_x));
  assign cy = clamp_q(word_t'(quat_y));
  assign cz = clamp_q(word_t'(quat_z));

  // divider step for each stage
  wide_t dv_rem_next [DIV_STG][NUM_ENT];
  quot_t dv_q_next   [DIV_STG][NUM_ENT];

  always_comb begin
    logic [64:0] t;
    for (int e = 0; e < NUM_ENT; e++) begin
      // first stage: integer bit
      if (s4_mag[e] >= s4_n) begin
        dv_rem_next[0][e] = s4_mag[e] - s4_n;
        dv_q_next[0][e]   = quot_t'(1);
      end else begin
        dv_rem_next[0][e] = s4_mag[e];
        dv_q_next[0][e]   = '0;
      end
      for (int k = 1; k < DIV_STG; k++) begin
        t = {dv_rem[k-1][e], 1'b0};
        if (t >= {1'b0, dv_n[k-1]}) begin
          dv_rem_next[k][e] = 64'(t - {1'b0, dv_n[k-1]});
          dv_q_next[k][e]   = {dv_q[k-1][e][Q_W-2:0], 1'b1};
        end else begin
          dv_rem_next[k][e] = t[63:0];
          dv_q_next[k][e]   = {dv_q[k-1][e][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // rounding of quotients, identity for a zero quaternion
  ent_t r_ent_next [NUM_ENT];
  always_comb begin
    logic [Q_W-1:0] rq;
    for (int e = 0; e < NUM_ENT; e++) begin
      rq = Q_W'((Q_W+1)'(dv_q[DIV_STG-1][e]) + (Q_W+1)'(1) >> 1);
      if (dv_zero[DIV_STG-1]) begin
        r_ent_next[e] = (e % 4 == 0) ? FRAC_ONE : '0;
      end else if (dv_neg[DIV_STG-1][e]) begin
        r_ent_next[e] = -ent_t'(rq);
      end else begin
        r_ent_next[e] = ent_t'(rq);
      end
    end
  end

  // product rounding and saturation
  word_t o_ent_next [NUM_ENT];
  always_comb begin
    logic [PROD_W:0]     pm;
    logic [PROD_W-16:0]  rm;
    logic signed [PROD_W-14:0] v;
    for (int e = 0; e < NUM_ENT; e++) begin
      pm = m_prod[e][PROD_W-1] ? (PROD_W+1)'(-(PROD_W+1)'(m_prod[e]))
                               : (PROD_W+1)'(m_prod[e]);
      rm = (PROD_W-15)'((pm + (PROD_W+1)'(32768)) >> 16);
      v  = m_prod[e][PROD_W-1] ? -(PROD_W-13)'(rm) : (PROD_W-13)'(rm);
      if (v > (PROD_W-13)'(WORD_MAX)) begin
        o_ent_next[e] = WORD_MAX;
      end else if (v < (PROD_W-13)'(WORD_MIN)) begin
        o_ent_next[e] = WORD_MIN;
      end else begin
        o_ent_next[e] = word_t'(v);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      dv_vld <= '0;
      vr <= 1'b0;
      vm <= 1'b0;
      vo <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      dv_vld <= {dv_vld[DIV_STG-2:0], v4};
      vr <= dv_vld[DIV_STG-1];
      vm <= vr;
      vo <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ww <= wide_t'(64'(cw) * 64'(cw));
      p_xx <= wide_t'(64'(cx) * 64'(cx));
      p_yy <= wide_t'(64'(cy) * 64'(cy));
      p_zz <= wide_t'(64'(cz) * 64'(cz));
      p_xy <= cx * cy;
      p_wz <= cw * cz;
      p_xz <= cx * cz;
      p_wy <= cw * cy;
      p_yz <= cy * cz;
      p_wx <= cw * cx;
      s1_scl <= '{word_t'(scale_x), word_t'(scale_y), word_t'(scale_z)};
      s1_pos <= '{word_t'(pos_x), word_t'(pos_y), word_t'(pos_z)};

      a_wx <= p_ww + p_xx;
      a_yz <= p_yy + p_zz;
      a_wy <= p_ww + p_yy;
      a_xz <= p_xx + p_zz;
      a_wz <= p_ww + p_zz;
      a_xy <= p_xx + p_yy;
      h01  <= 65'(p_xy) - 65'(p_wz);
      h02  <= 65'(p_xz) + 65'(p_wy);
      h10  <= 65'(p_xy) + 65'(p_wz);
      h12  <= 65'(p_yz) - 65'(p_wx);
      h20  <= 65'(p_xz) - 65'(p_wy);
      h21  <= 65'(p_yz) + 65'(p_wx);
      s2_scl <= s1_scl;
      s2_pos <= s1_pos;

      s3_n    <= a_wx + a_yz;
      s3_d[0] <= numer_t'({2'b00, a_wx}) - numer_t'({2'b00, a_yz});
      s3_d[1] <= {h01, 1'b0};
      s3_d[2] <= {h02, 1'b0};
      s3_d[3] <= {h10, 1'b0};
      s3_d[4] <= numer_t'({2'b00, a_wy}) - numer_t'({2'b00, a_xz});
      s3_d[5] <= {h12, 1'b0};
      s3_d[6] <= {h20, 1'b0};
      s3_d[7] <= {h21, 1'b0};
      s3_d[8] <= numer_t'({2'b00, a_wz}) - numer_t'({2'b00, a_xy});
      s3_scl  <= s2_scl;
      s3_pos  <= s2_pos;

      s4_n    <= s3_n;
      s4_zero <= (s3_n == '0);
      for (int e = 0; e < NUM_ENT; e++) begin
        s4_neg[e] <= s3_d[e][65];
        // magnitude never exceeds the norm
        s4_mag[e] <= s3_d[e][65] ? 64'(-s3_d[e]) : s3_d[e][63:0];
      end
      s4_scl <= s3_scl;
      s4_pos <= s3_pos;

      dv_n[0]    <= s4_n;
      dv_zero[0] <= s4_zero;
      dv_neg[0]  <= s4_neg;
      dv_scl[0]  <= s4_scl;
      dv_pos[0]  <= s4_pos;
      for (int k = 1; k < DIV_STG; k++) begin
        dv_n[k]    <= dv_n[k-1];
        dv_zero[k] <= dv_zero[k-1];
        dv_neg[k]  <= dv_neg[k-1];
        dv_scl[k]  <= dv_scl[k-1];
        dv_pos[k]  <= dv_pos[k-1];
      end
      dv_rem <= dv_rem_next;
      dv_q   <= dv_q_next;

      r_ent <= r_ent_next;
      r_scl <= dv_scl[DIV_STG-1];
      r_pos <= dv_pos[DIV_STG-1];

      for (int e = 0; e < NUM_ENT; e++) begin
        m_prod[e] <= r_ent[e] * r_scl[e % 3];
      end
      m_pos <= r_pos;

      o_ent <= o_ent_next;
      o_pos <= m_pos;
    end
  end

  assign result_valid = vo;
  assign m00 = o_ent[0];
  assign m01 = o_ent[1];
  assign m02 = o_ent[2];
  assign m03 = o_pos[0];
  assign m10 = o_ent[3];
  assign m11 = o_ent[4];
  assign m12 = o_ent[5];
  assign m13 = o_pos[1];
  assign m20 = o_ent[6];
  assign m21 = o_ent[7];
  assign m22 = o_ent[8];
  assign m23 = o_pos[2];

  a_enter: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> v1)
    else $error("accepted item did not enter the pipe");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(dv_vld) && $stable(v4))
    else $error("pipe moved while the result was stalled");

  a_ent_range: assert property (@(posedge clk) disable iff (rst)
    vr |-> (r_ent[0] <= FRAC_ONE) && (r_ent[0] >= -FRAC_ONE))
    else $error("rotation entry out of unit range");

endmodule
